// ===== design/bmp_rle8_stream_decoder_assert.svh =====
// Assertion macros for the RLE8 stream decoder.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef BMP_RLE8_STREAM_DECODER_ASSERT_SVH
`define BMP_RLE8_STREAM_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRLE8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRLE8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/brle8_pkg.sv =====
// Shared types and constants of the RLE8 stream decoder.
// No dependencies; used by the channel interfaces and the top level.
package brle8_pkg;

    localparam int DIM_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ADDR_BITS      = 24;
    localparam int PIXELS_BITS    = 2 * DIM_BITS;
    localparam int ANCHOR_BITS    = 27;

    localparam logic signed [ANCHOR_BITS:0] ANCHOR_MAX = 28'sd67108863;
    localparam logic signed [ANCHOR_BITS:0] ANCHOR_MIN = -28'sd67108864;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_TOP_DOWN = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_SPAN = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_DX      = 3'd2,
        PH_DY      = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    // Escape codes that follow a zero count byte.
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_BITS-1:0] address;
        logic [7:0]           span_length;
        logic [7:0]           pixel_value;
        logic                 end_of_item;
    } t_result;

endpackage

// ===== design/brle8_in_if.sv =====
// Input channel of the RLE8 stream decoder: one encoded byte per item.
// Depends on brle8_pkg.
interface brle8_in_if;
    import brle8_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, stream_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, stream_byte, first_byte, last_byte, output ready);
endinterface

// ===== design/brle8_out_if.sv =====
// Result channel of the RLE8 stream decoder: span writes and status items.
// Depends on brle8_pkg.
interface brle8_out_if;
    import brle8_pkg::*;

    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           span_length;
    logic [7:0]           pixel_value;
    logic                 end_of_item;

    modport source (output valid, kind, address, span_length, pixel_value, end_of_item,
                    input ready);
    modport sink   (input valid, kind, address, span_length, pixel_value, end_of_item,
                    output ready);
endinterface

// ===== design/bmp_rle8_stream_decoder.sv =====
// Top level of the BMP RLE8 stream decoder: parser, cursor arithmetic, result queue.
// Depends on brle8_pkg, brle8_in_if, brle8_out_if and the assertion header.
//
// Usage: feed the RLE8 pixel data one byte per item on i_in; mark the first
// byte of an image with first_byte and the final byte with last_byte. Each
// item on o_out is either a span write (kind span: span_length pixels of
// pixel_value starting at address) or a status item (finished ok or
// malformed) that closes the decode. The end_of_item flag marks the last
// result that a byte caused. Writes seen before a malformed status are to be
// dropped by the consumer.
// Configuration (width, height, row order) is written through the plain
// write port while the block is idle; a new image picks it up at first_byte.
// A byte accepted on i_in waits in the input register, is parsed from there into
// the result queue, and its results are driven from the head of the queue.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver takes every result; a byte that gives two results (a write
// followed by the malformed status of a cut-short stream) holds up the next byte,
// since the three-entry result queue parses only while it holds at most one entry.
// Reset empties the input register and the queue and restores the default
// configuration (1 x 1, bottom-up). When the receiver stalls, results wait
// in the queue, the input register fills, and then i_in.ready drops.
module bmp_rle8_stream_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [brle8_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [brle8_pkg::DIM_BITS-1:0]       i_cfg_data,
    brle8_in_if.sink                            i_in,
    brle8_out_if.source                         o_out
);
    import brle8_pkg::*;

    `include "bmp_rle8_stream_decoder_assert.svh"

    // Configuration registers and the values derived from them when written.
    logic [DIM_BITS-1:0]           r_width,     n_width;
    logic [DIM_BITS-1:0]           r_height,    n_height;
    logic                          r_top_down,  n_top_down;
    logic [PIXELS_BITS-1:0]        r_pixels,    n_pixels;
    logic signed [ANCHOR_BITS-1:0] r_last_row,  n_last_row;

    // Input register.
    logic  r_in_valid;
    t_item r_in;

    // Parser state.
    t_phase                        r_phase,    n_phase;
    logic [7:0]                    r_run,      n_run;
    logic [7:0]                    r_dx,       n_dx;
    logic signed [ANCHOR_BITS-1:0] r_anchor,   n_anchor;
    logic signed [ANCHOR_BITS-1:0] r_cursor,   n_cursor;
    logic [7:0]                    r_left,     n_left;
    logic                          r_pad,      n_pad;
    logic                          r_finished, n_finished;

    // State after the optional restart at first_byte.
    t_phase                        e_phase;
    logic [7:0]                    e_run, e_dx, e_left;
    logic signed [ANCHOR_BITS-1:0] e_anchor, e_cursor;
    logic                          e_pad, e_fin;

    // Arithmetic for the current byte.
    logic [7:0]                    w_b;
    logic signed [ANCHOR_BITS+1:0] w_pix29, w_cur29, w_room;
    logic signed [DIM_BITS:0]      w_step;
    logic signed [ANCHOR_BITS:0]   w_eol_sum;
    logic signed [ANCHOR_BITS-1:0] w_eol_anchor;
    logic [DIM_BITS+7:0]           w_prod;
    logic signed [DIM_BITS+8:0]    w_dy;
    logic signed [ANCHOR_BITS:0]   w_dy_anchor, w_dy_cur;

    // Results of the current byte.
    logic    w_span_en, w_prim_st, w_st_en;
    t_kind   w_prim_kind;
    t_result w_span, w_status, w_res0, w_res1;
    logic [1:0] w_push_n;

    // Result queue; entry 0 drives the output.
    t_result    r_q [0:2];
    t_result    n_q [0:2];
    logic [1:0] r_q_count, n_q_count, w_base;
    logic       w_pop, w_proc;

    function automatic logic signed [ANCHOR_BITS-1:0] clamp_anchor(
        input logic signed [ANCHOR_BITS:0] a
    );
        logic signed [ANCHOR_BITS-1:0] res;
        if (a > ANCHOR_MAX) begin
            res = ANCHOR_MAX[ANCHOR_BITS-1:0];
        end else if (a < ANCHOR_MIN) begin
            res = ANCHOR_MIN[ANCHOR_BITS-1:0];
        end else begin
            res = a[ANCHOR_BITS-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration. The pixel total and the start of the last row are
    // computed with the write, so a parsed byte only reads registers.
    // ------------------------------------------------------------------
    always_comb begin
        n_width    = r_width;
        n_height   = r_height;
        n_top_down = r_top_down;
        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:    n_width    = i_cfg_data;
                CFG_HEIGHT:   n_height   = i_cfg_data;
                CFG_TOP_DOWN: n_top_down = i_cfg_data[0];
                default:      ;
            endcase
        end
        n_pixels   = n_width * n_height;
        n_last_row = $signed({1'b0, n_pixels}) - $signed({{(ANCHOR_BITS-DIM_BITS){1'b0}}, n_width});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_BITS'(1);
            r_height   <= DIM_BITS'(1);
            r_top_down <= 1'b0;
            r_pixels   <= PIXELS_BITS'(1);
            r_last_row <= '0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_top_down <= n_top_down;
            r_pixels   <= n_pixels;
            r_last_row <= n_last_row;
        end
    end

    // ------------------------------------------------------------------
    // Input register. A byte is parsed when the queue holds at most one
    // result, which leaves room for the two that a byte can cause.
    // ------------------------------------------------------------------
    assign w_proc     = r_in_valid && (r_q_count <= 2'd1);
    assign i_in.ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.stream_byte <= i_in.stream_byte;
            r_in.first_byte  <= i_in.first_byte;
            r_in.last_byte   <= i_in.last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser: next state and results of the byte in the input register.
    // ------------------------------------------------------------------
    always_comb begin
        w_b = r_in.stream_byte;

        // A first byte restarts the image before it is parsed.
        if (r_in.first_byte) begin
            e_phase  = PH_COUNT;
            e_run    = '0;
            e_dx     = '0;
            e_left   = '0;
            e_pad    = 1'b0;
            e_fin    = 1'b0;
            e_anchor = r_top_down ? '0 : r_last_row;
            e_cursor = r_top_down ? '0 : r_last_row;
        end else begin
            e_phase  = r_phase;
            e_run    = r_run;
            e_dx     = r_dx;
            e_left   = r_left;
            e_pad    = r_pad;
            e_fin    = r_finished;
            e_anchor = r_anchor;
            e_cursor = r_cursor;
        end

        n_phase  = e_phase;
        n_run    = e_run;
        n_dx     = e_dx;
        n_left   = e_left;
        n_pad    = e_pad;
        n_anchor = e_anchor;
        n_cursor = e_cursor;

        // Room left in the image from the cursor to the end.
        w_pix29 = $signed({3'b000, r_pixels});
        w_cur29 = $signed({{2{e_cursor[ANCHOR_BITS-1]}}, e_cursor});
        w_room  = w_pix29 - w_cur29;

        // Row step, signed by the row order.
        w_step = r_top_down ? $signed({1'b0, r_width}) : -$signed({1'b0, r_width});

        // End of line: next row anchor.
        w_eol_sum    = $signed({e_anchor[ANCHOR_BITS-1], e_anchor})
                     + $signed({{(ANCHOR_BITS-DIM_BITS){w_step[DIM_BITS]}}, w_step});
        w_eol_anchor = clamp_anchor(w_eol_sum);

        // Delta: vertical move of dy rows, then the new cursor.
        w_prod      = r_width * w_b;
        w_dy        = r_top_down ? $signed({1'b0, w_prod}) : -$signed({1'b0, w_prod});
        w_dy_anchor = $signed({e_anchor[ANCHOR_BITS-1], e_anchor})
                    + $signed({{(ANCHOR_BITS-DIM_BITS-8){w_dy[DIM_BITS+8]}}, w_dy});
        w_dy_cur    = $signed({e_cursor[ANCHOR_BITS-1], e_cursor})
                    + $signed({{(ANCHOR_BITS-7){1'b0}}, e_dx})
                    + $signed({{(ANCHOR_BITS-DIM_BITS-8){w_dy[DIM_BITS+8]}}, w_dy});

        w_span_en   = 1'b0;
        w_prim_st   = 1'b0;
        w_prim_kind = KIND_OK;

        w_span.kind        = KIND_SPAN;
        w_span.address     = e_cursor[ADDR_BITS-1:0];
        w_span.span_length = e_run;
        w_span.pixel_value = w_b;
        w_span.end_of_item = 1'b0;

        if (!e_fin) begin
            unique case (e_phase)
                PH_COUNT: begin
                    n_run   = w_b;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    n_phase = PH_COUNT;
                    if (e_run != 8'd0) begin
                        // Encoded run: one span write if it fits in the image.
                        if ($signed({21'b0, e_run}) > w_room) begin
                            w_prim_st   = 1'b1;
                            w_prim_kind = KIND_BAD;
                        end else begin
                            w_span_en = 1'b1;
                            n_cursor  = e_cursor + $signed({19'b0, e_run});
                        end
                    end else begin
                        unique case (w_b)
                            ESC_EOL: begin
                                n_anchor = w_eol_anchor;
                                n_cursor = w_eol_anchor;
                                // Stepping off the image ends the decode cleanly.
                                if (w_eol_anchor[ANCHOR_BITS-1] ||
                                    $signed({{2{w_eol_anchor[ANCHOR_BITS-1]}}, w_eol_anchor})
                                        >= w_pix29) begin
                                    w_prim_st   = 1'b1;
                                    w_prim_kind = KIND_OK;
                                end
                            end
                            ESC_EOB: begin
                                w_prim_st   = 1'b1;
                                w_prim_kind = KIND_OK;
                            end
                            ESC_DELTA: begin
                                n_phase = PH_DX;
                            end
                            default: begin
                                // Absolute mode: the whole literal run must fit.
                                if ($signed({21'b0, w_b}) > w_room) begin
                                    w_prim_st   = 1'b1;
                                    w_prim_kind = KIND_BAD;
                                end else begin
                                    n_left  = w_b;
                                    n_pad   = w_b[0];
                                    n_phase = PH_LITERAL;
                                end
                            end
                        endcase
                    end
                end
                PH_DX: begin
                    n_dx    = w_b;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_phase  = PH_COUNT;
                    n_anchor = clamp_anchor(w_dy_anchor);
                    if (w_dy_cur[ANCHOR_BITS] ||
                        $signed({w_dy_cur[ANCHOR_BITS], w_dy_cur}) > w_pix29) begin
                        w_prim_st   = 1'b1;
                        w_prim_kind = KIND_BAD;
                    end else begin
                        n_cursor = w_dy_cur[ANCHOR_BITS-1:0];
                    end
                end
                PH_LITERAL: begin
                    w_span_en          = 1'b1;
                    w_span.span_length = 8'd1;
                    n_cursor           = e_cursor + $signed(27'sd1);
                    n_left             = e_left - 8'd1;
                    if (n_left == 8'd0) begin
                        n_phase = e_pad ? PH_PAD : PH_COUNT;
                    end
                end
                default: begin
                    // Pad byte after an odd literal run.
                    n_pad   = 1'b0;
                    n_phase = PH_COUNT;
                end
            endcase
        end

        // A stream that stops without an end code is malformed.
        w_st_en = w_prim_st || (!e_fin && r_in.last_byte);

        w_status.kind        = w_prim_st ? w_prim_kind : KIND_BAD;
        w_status.address     = '0;
        w_status.span_length = '0;
        w_status.pixel_value = '0;
        w_status.end_of_item = 1'b1;

        n_finished = e_fin || w_st_en;

        if (w_span_en) begin
            w_res0             = w_span;
            w_res0.end_of_item = !w_st_en;
        end else begin
            w_res0 = w_status;
        end
        w_res1   = w_status;
        w_push_n = {1'b0, w_span_en} + {1'b0, w_st_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COUNT;
            r_run      <= '0;
            r_dx       <= '0;
            r_left     <= '0;
            r_pad      <= 1'b0;
            r_finished <= 1'b0;
            r_anchor   <= '0;
            r_cursor   <= '0;
        end else if (w_proc) begin
            r_phase    <= n_phase;
            r_run      <= n_run;
            r_dx       <= n_dx;
            r_left     <= n_left;
            r_pad      <= n_pad;
            r_finished <= n_finished;
            r_anchor   <= n_anchor;
            r_cursor   <= n_cursor;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: shifts down on a take, new results land behind the
    // entries that remain.
    // ------------------------------------------------------------------
    always_comb begin
        w_pop  = (r_q_count != 2'd0) && o_out.ready;
        w_base = r_q_count - {1'b0, w_pop};

        n_q[0] = w_pop ? r_q[1] : r_q[0];
        n_q[1] = w_pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];

        if (w_proc) begin
            if (w_push_n != 2'd0) begin
                n_q[w_base] = w_res0;
            end
            if (w_push_n == 2'd2) begin
                n_q[w_base + 2'd1] = w_res1;
            end
        end
        n_q_count = w_base + (w_proc ? w_push_n : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_count <= '0;
        end else begin
            r_q_count <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
    end

    assign o_out.valid       = (r_q_count != 2'd0);
    assign o_out.kind        = r_q[0].kind;
    assign o_out.address     = r_q[0].address;
    assign o_out.span_length = r_q[0].span_length;
    assign o_out.pixel_value = r_q[0].pixel_value;
    assign o_out.end_of_item = r_q[0].end_of_item;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `BRLE8_ASSERT_NOW(a_quiet_after_end, w_proc && r_finished && !r_in.first_byte, w_push_n == 2'd0, "byte after end of decode gave a result")
    `BRLE8_ASSERT_NOW(a_status_closes_item, o_out.valid && (o_out.kind != KIND_SPAN), o_out.end_of_item, "status item not last of its byte")
    `BRLE8_ASSERT_NEXT(a_status_finishes, w_proc && w_st_en, r_finished, "status given but decode not finished")

endmodule

// ===== bench/brle8_decode_checker.sv =====
// Scoreboard for the RLE8 stream decoder: a cycle-free decoder model plus result comparison.
// Depends on brle8_pkg, brle8_in_if and brle8_out_if; watches the channels and the write port.
module brle8_decode_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [brle8_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [brle8_pkg::DIM_BITS-1:0]       i_cfg_data,
    brle8_in_if                                  i_in_mon,
    brle8_out_if                                 i_out_mon,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import brle8_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the configuration registers.
    logic [DIM_BITS-1:0] img_w;
    logic [DIM_BITS-1:0] img_h;
    logic                rows_top_first;

    // Parser state of the model.
    t_phase     phase;
    logic [7:0] run_len;
    logic [7:0] skip_x;
    logic [7:0] lit_left;
    logic       pad_due;
    logic       done;
    longint     anchor;
    longint     cursor;

    // Pixel writes and status items still owed by the block, oldest first.
    t_result pixel_ops_q[$];
    int      fails = 0;

    function automatic longint total_pixels();
        return longint'(img_w) * longint'(img_h);
    endfunction

    function automatic longint line_stride();
        return rows_top_first ? longint'(img_w) : -longint'(img_w);
    endfunction

    function automatic longint clamp_anchor(input longint a);
        if (a > longint'(ANCHOR_MAX)) return longint'(ANCHOR_MAX);
        if (a < longint'(ANCHOR_MIN)) return longint'(ANCHOR_MIN);
        return a;
    endfunction

    task automatic restart_image();
        phase    = PH_COUNT;
        run_len  = '0;
        skip_x   = '0;
        lit_left = '0;
        pad_due  = 1'b0;
        done     = 1'b0;
        anchor   = rows_top_first ? 64'sd0 : total_pixels() - longint'(img_w);
        cursor   = anchor;
    endtask

    task automatic push_op(input t_kind k, input longint addr, input logic [7:0] len,
                           input logic [7:0] val);
        t_result r;
        r.kind        = k;
        r.address     = addr[ADDR_BITS-1:0];
        r.span_length = len;
        r.pixel_value = val;
        r.end_of_item = 1'b0;
        pixel_ops_q.push_back(r);
    endtask

    task automatic close_decode(input t_kind k);
        push_op(k, 64'sd0, 8'd0, 8'd0);
        done = 1'b1;
    endtask

    // Advances the model by one encoded byte and queues whatever it writes.
    task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
        longint  pixels;
        longint  dy_move;
        longint  next_pos;
        int      mark;
        t_result tail;
        mark = pixel_ops_q.size();
        if (first) restart_image();
        if (!done) begin
            pixels = total_pixels();
            case (phase)
                PH_COUNT: begin
                    run_len = b;
                    phase   = PH_VALUE;
                end
                PH_VALUE: begin
                    phase = PH_COUNT;
                    if (run_len != 8'd0) begin
                        if (longint'(run_len) > pixels - cursor) begin
                            close_decode(KIND_BAD);
                        end else begin
                            push_op(KIND_SPAN, cursor, run_len, b);
                            cursor = cursor + longint'(run_len);
                        end
                    end else if (b == ESC_EOL) begin
                        anchor = clamp_anchor(anchor + line_stride());
                        cursor = anchor;
                        if (anchor < 0 || anchor >= pixels) close_decode(KIND_OK);
                    end else if (b == ESC_EOB) begin
                        close_decode(KIND_OK);
                    end else if (b == ESC_DELTA) begin
                        phase = PH_DX;
                    end else if (longint'(b) > pixels - cursor) begin
                        // A literal run that cannot fit is refused on its length byte.
                        close_decode(KIND_BAD);
                    end else begin
                        lit_left = b;
                        pad_due  = b[0];
                        phase    = PH_LITERAL;
                    end
                end
                PH_DX: begin
                    skip_x = b;
                    phase  = PH_DY;
                end
                PH_DY: begin
                    dy_move  = line_stride() * longint'(b);
                    next_pos = cursor + longint'(skip_x) + dy_move;
                    phase    = PH_COUNT;
                    anchor   = clamp_anchor(anchor + dy_move);
                    if (next_pos < 0 || next_pos > pixels) begin
                        close_decode(KIND_BAD);
                    end else begin
                        cursor = next_pos;
                    end
                end
                PH_LITERAL: begin
                    push_op(KIND_SPAN, cursor, 8'd1, b);
                    cursor   = cursor + 64'sd1;
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 8'd0) phase = pad_due ? PH_PAD : PH_COUNT;
                end
                default: begin
                    pad_due = 1'b0;
                    phase   = PH_COUNT;
                end
            endcase
            // The stream stopped without an end code.
            if (last && !done) close_decode(KIND_BAD);
        end
        if (pixel_ops_q.size() > mark) begin
            tail = pixel_ops_q.pop_back();
            tail.end_of_item = 1'b1;
            pixel_ops_q.push_back(tail);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.kind        = i_out_mon.kind;
        got.address     = i_out_mon.address;
        got.span_length = i_out_mon.span_length;
        got.pixel_value = i_out_mon.pixel_value;
        got.end_of_item = i_out_mon.end_of_item;
        if (pixel_ops_q.size() == 0) begin
            if (fails < REPORT_LIMIT)
                $display("unexpected result: kind %0d addr %0d len %0d value %0d end %0b",
                         got.kind, got.address, got.span_length, got.pixel_value,
                         got.end_of_item);
            fails++;
        end else begin
            want = pixel_ops_q.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.span_length !== want.span_length || got.pixel_value !== want.pixel_value ||
                got.end_of_item !== want.end_of_item) begin
                if (fails < REPORT_LIMIT) begin
                    $display("mismatch: expected kind %0d addr %0d len %0d value %0d end %0b",
                             want.kind, want.address, want.span_length, want.pixel_value,
                             want.end_of_item);
                    $display("          got      kind %0d addr %0d len %0d value %0d end %0b",
                             got.kind, got.address, got.span_length, got.pixel_value,
                             got.end_of_item);
                end
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            img_w          = 13'd1;
            img_h          = 13'd1;
            rows_top_first = 1'b0;
            restart_image();
            pixel_ops_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) check_result();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:    img_w = i_cfg_data;
                    CFG_HEIGHT:   img_h = i_cfg_data;
                    CFG_TOP_DOWN: rows_top_first = i_cfg_data[0];
                    default:      ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                decode_byte(i_in_mon.stream_byte, i_in_mon.first_byte, i_in_mon.last_byte);
        end
        o_fail_count = fails;
        o_pending    = pixel_ops_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// Top of the RLE8 stream decoder bench: clock, reset, configuration and stimulus.
// Depends on brle8_pkg, both channel interfaces, the decoder and brle8_decode_checker.
module tb;
    import brle8_pkg::*;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int MIN_PHASES    = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 2000000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_WIDTH;
    logic [DIM_BITS-1:0]       cfg_data  = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Handshake shaping: squeeze_req asks the receiver for one long hold-off, and
    // steady turns off all idling on both sides for one phase.
    bit squeeze_req = 1'b0;
    bit steady      = 1'b0;
    int stall_left  = 0;
    int hold_left   = 0;

    // Image width currently programmed; the stream generator sizes its runs by it.
    int cur_w = 1;

    // Encoded bytes waiting to be sent, each packed as {byte, first_byte, last_byte}.
    logic [9:0] byte_q[$];
    bit         start_next = 1'b0;

    brle8_in_if  in_ch();
    brle8_out_if out_ch();

    bmp_rle8_stream_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    brle8_decode_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result receiver. All changes happen at the falling edge, the first one while
    // reset is still asserted. A squeeze request holds ready low while hold_left
    // counts down, so that the result queue and the input register fill and the block
    // has to stall its input.
    always @(negedge clk) begin
        if (squeeze_req) begin
            squeeze_req = 1'b0;
            hold_left   = HOLD_CYCLES;
            stall_left  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (steady) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // The next byte queued opens a new image.
    task automatic begin_image();
        start_next = 1'b1;
    endtask

    task automatic add_byte(input int b, input bit last = 1'b0);
        byte_q.push_back({b[7:0], start_next, last});
        start_next = 1'b0;
    endtask

    // Offers one item after an optional idle gap and returns at the falling edge
    // that follows its acceptance. Valid stays high when the next item follows at once.
    task automatic push_byte(input logic [9:0] ent);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.stream_byte, in_ch.first_byte, in_ch.last_byte} <= ent;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Valid is left high at the end so that a following image can go on at once.
    task automatic send_all();
        while (byte_q.size() > 0) push_byte(byte_q.pop_front());
    endtask

    // Drops valid, waits until every predicted result has come, then lets the block
    // settle, since a trailing byte such as a count byte leaves nothing to wait for.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Programs all three registers on consecutive cycles; the block must be idle.
    task automatic configure(input int w, input int h, input int td);
        cur_w = w;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w[DIM_BITS-1:0];
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h[DIM_BITS-1:0];
        @(negedge clk);
        cfg_index <= CFG_TOP_DOWN;
        cfg_data  <= td[DIM_BITS-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Builds one encoded image. Most operations are well formed with random
    // content; a few stray bytes knock the parser out of step. The ending is
    // an end-of-bitmap on the last byte, a stream cut short, or an end-of-bitmap
    // followed by bytes the block has to ignore.
    task automatic build_image(input int n_ops, input int ending);
        int r;
        int n;
        int lim;
        int i;
        int k;
        logic [9:0] tail;
        lim = (cur_w < 1) ? 4 : ((cur_w > 255) ? 255 : cur_w);
        begin_image();
        for (i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                n = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, lim);
                add_byte(n);
                add_byte($urandom_range(0, 255));
            end else if (r < 60) begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(3, 255)
                                                 : $urandom_range(3, 24);
                add_byte(0);
                add_byte(n);
                for (k = 0; k < n; k++) add_byte($urandom_range(0, 255));
                // Odd literal runs carry a pad byte to keep word alignment.
                if (n % 2 == 1) add_byte($urandom_range(0, 255));
            end else if (r < 75) begin
                add_byte(0);
                add_byte(ESC_EOL);
            end else if (r < 90) begin
                add_byte(0);
                add_byte(ESC_DELTA);
                if ($urandom_range(0, 9) == 0) begin
                    add_byte(255);
                    add_byte(255);
                end else begin
                    add_byte($urandom_range(0, lim));
                    add_byte($urandom_range(0, 2));
                end
            end else begin
                add_byte($urandom_range(0, 255));
            end
        end
        if (ending == 0) begin
            add_byte(0);
            add_byte(ESC_EOB, 1'b1);
        end else if (ending == 1) begin
            if (byte_q.size() == 0) begin
                add_byte($urandom_range(0, 255), 1'b1);
            end else begin
                tail = byte_q.pop_back();
                tail[0] = 1'b1;
                byte_q.push_back(tail);
            end
        end else begin
            add_byte(0);
            add_byte(ESC_EOB);
            add_byte($urandom_range(0, 255));
            add_byte($urandom_range(0, 255), 1'b1);
        end
    endtask

    initial begin
        int phase_no;
        int random_sent;
        int r;
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = '0;
        in_ch.first_byte  = 1'b0;
        in_ch.last_byte   = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, largest image stored bottom-up: the longest run with all
        // value bits set lands at the start of the last row, then an odd literal
        // run with its pad byte, the widest delta, and end-of-bitmap.
        configure(4096, 4096, 0);
        begin_image();
        add_byte(255);
        add_byte(255);
        add_byte(0);
        add_byte(3);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        add_byte(8'hA5);
        add_byte(0);
        add_byte(ESC_DELTA);
        add_byte(255);
        add_byte(255);
        add_byte(0);
        add_byte(ESC_EOB, 1'b1);
        send_all();
        wait_drained();

        // Directed part, one-pixel image stored top first: each image hits one
        // error or end case.
        configure(1, 1, 1);
        begin_image();                  // run longer than the space left
        add_byte(2);
        add_byte(9);
        begin_image();                  // literal run that cannot fit
        add_byte(0);
        add_byte(3);
        begin_image();                  // delta that steps past the image
        add_byte(0);
        add_byte(ESC_DELTA);
        add_byte(2);
        add_byte(0);
        begin_image();                  // end of line leaves the image, then a
        add_byte(0);                    // stray last byte after the end is ignored
        add_byte(ESC_EOL);
        add_byte(8'h33, 1'b1);
        begin_image();                  // one byte gives a write and a malformed status
        add_byte(1);
        add_byte(9, 1'b1);
        begin_image();                  // stream cut short after a count byte
        add_byte(8'h7E, 1'b1);
        send_all();
        wait_drained();

        // Random part. Each phase programs a new geometry and sends a few images.
        // The first phase carries the long receiver hold-off, one phase runs with
        // no idling at all, and some phases use the extreme geometries, including
        // a zero width and a zero height where every write is out of bounds.
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS || phase_no < MIN_PHASES) begin
            case (phase_no)
                1:       configure(4096, 4096, 0);
                2:       configure(4096, 4096, 1);
                3:       configure(1, 4096, 1);
                4:       configure(4096, 1, 0);
                5:       configure(0, $urandom_range(1, 8), $urandom_range(0, 1));
                6:       configure($urandom_range(1, 8), 0, $urandom_range(0, 1));
                default: configure($urandom_range(1, 40), $urandom_range(1, 20),
                                   $urandom_range(0, 1));
            endcase
            if (phase_no == 0) squeeze_req = 1'b1;
            steady = (phase_no == 7);
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 9);
                build_image($urandom_range(4, 24), (r < 6) ? 0 : ((r < 8) ? 1 : 2));
                random_sent += byte_q.size();
                send_all();
            end
            steady = 1'b0;
            wait_drained();
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
